// File: sv/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, constants and the CRC-8 byte update for the command frame
// detector.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'h55;
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] CMD_ID    = 8'h01;
  localparam logic [7:0] CMD_SELF  = 8'h02;
  localparam logic [7:0] DATA_ZERO = 8'h00;

  localparam logic KIND_ID   = 1'b0;
  localparam logic KIND_SELF = 1'b1;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_CMD  = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4
  } phase_t;

  typedef struct packed {
    logic hit;
    logic kind;
  } result_t;

  // msb-first, init 0, no reflection, no final xor
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/cfd_frame_tracker.sv
// ----------------------------------------------------------------------------
// cfd_frame_tracker
// Frame phase machine, running CRC and captured command/data bytes. One
// word is consumed per cycle when byte_vld is high.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_frame_tracker (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            byte_vld,
  input  wire logic [7:0]      byte_val,
  output cfd_pkg::result_t     result
);

  cfd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      crc_r, crc_nxt;
  logic [7:0]      cmd_r, cmd_nxt;
  logic [7:0]      data_r, data_nxt;
  logic [7:0]      crc_upd;
  logic            is_hdr;

  assign crc_upd = cfd_pkg::crc8_feed(crc_r, byte_val);
  assign is_hdr  = (byte_val == cfd_pkg::HDR_BYTE);

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      cfd_pkg::PH_HDR2: begin
        phase_nxt = is_hdr ? cfd_pkg::PH_CMD : cfd_pkg::PH_HDR1;
      end
      cfd_pkg::PH_CMD: begin
        phase_nxt = cfd_pkg::PH_DATA;
      end
      cfd_pkg::PH_DATA: begin
        phase_nxt = cfd_pkg::PH_CRC;
      end
      cfd_pkg::PH_CRC: begin
        phase_nxt = cfd_pkg::PH_HDR1;
      end
      default: begin
        phase_nxt = is_hdr ? cfd_pkg::PH_HDR2 : cfd_pkg::PH_HDR1;
      end
    endcase
  end

  always_comb begin
    crc_nxt     = crc_r;
    cmd_nxt     = cmd_r;
    data_nxt    = data_r;
    result.hit  = 1'b0;
    result.kind = cfd_pkg::KIND_ID;
    case (phase_r)
      cfd_pkg::PH_HDR2: begin
        crc_nxt = is_hdr ? crc_upd : 8'h00;
      end
      cfd_pkg::PH_CMD: begin
        cmd_nxt = byte_val;
        crc_nxt = crc_upd;
      end
      cfd_pkg::PH_DATA: begin
        data_nxt = byte_val;
        crc_nxt  = crc_upd;
      end
      cfd_pkg::PH_CRC: begin
        crc_nxt = 8'h00;
        if ((byte_val == crc_r) && (data_r == cfd_pkg::DATA_ZERO)) begin
          if (cmd_r == cfd_pkg::CMD_ID) begin
            result.hit  = byte_vld;
            result.kind = cfd_pkg::KIND_ID;
          end else if (cmd_r == cfd_pkg::CMD_SELF) begin
            result.hit  = byte_vld;
            result.kind = cfd_pkg::KIND_SELF;
          end
        end
      end
      default: begin
        // running crc is zero here, so feeding from crc_r equals feeding from 0
        crc_nxt = is_hdr ? cfd_pkg::crc8_feed(8'h00, byte_val) : 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cfd_pkg::PH_HDR1;
      crc_r   <= 8'h00;
      cmd_r   <= 8'h00;
      data_r  <= 8'h00;
    end else if (byte_vld) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      cmd_r   <= cmd_nxt;
      data_r  <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/crc8_command_frame_detector_core.sv
// ----------------------------------------------------------------------------
// crc8_command_frame_detector_core
// Scans received bytes for 55 55 CMD DATA CRC frames and reports identity
// and self test requests.
//
//   channel  ports                          direction
//   in       in_valid in_stall in_rx_byte   word in, stall out
//   out      out_valid out_stall            word out, stall in
//            out_command_kind
//
// One word per cycle sustained unless out_stall holds a full result register.
// Path: input register, then the frame tracker decides and loads the result register.
// The tracker consumes a staged word whenever the result register is empty
// or being taken; out_stall reaches in_stall combinationally.
// Synchronous active-low reset returns the tracker to first header.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_command_frame_detector_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_command_kind
);

  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic             out_vld_r;
  logic             out_kind_r;
  logic             out_free;
  logic             advance;
  logic             in_fire;
  cfd_pkg::result_t res;

  assign out_free = !out_vld_r || !out_stall;
  assign advance  = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  cfd_frame_tracker u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (advance),
    .byte_val (in_byte_r),
    .result   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.hit) begin
      out_kind_r <= res.kind;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_command_kind = out_kind_r;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CRC-8 command frame detector. A queue of bytes
// (directed frames, then random frames, broken headers and noise) feeds a
// valid/stall driver. A frame tracker predicts the command kind of every
// good frame, and a monitor checks each result word in order. Both sides
// idle and stall at random, in phases.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_command_kind;

  crc8_command_frame_detector_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command_kind (out_command_kind)
  );

  always #5 clk = ~clk;

  logic [7:0] rx_queue[$];
  logic       kind_expect[$];
  int         words_queued = 0;
  int         words_in = 0;
  int         errors = 0;
  int         quiet_cycles = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  bit         tx_pause = 1'b0;
  bit         hold_go = 1'b0;
  int         hold_cnt = 0;
  bit         in_fire = 1'b0;

  // frame tracker state
  cfd_pkg::phase_t trk_phase;
  logic [7:0]      trk_crc;
  logic [7:0]      trk_cmd;
  logic [7:0]      trk_data;

  function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r = {r[6:0], 1'b0} ^ ({8{fb}} & cfd_pkg::CRC_POLY);
    end
    return r;
  endfunction

  function automatic void track_byte(input logic [7:0] b, output logic hit,
                                     output logic kind);
    hit = 1'b0;
    kind = cfd_pkg::KIND_ID;
    case (trk_phase)
      cfd_pkg::PH_HDR2: begin
        if (b == cfd_pkg::HDR_BYTE) begin
          trk_crc = crc_next(trk_crc, b);
          trk_phase = cfd_pkg::PH_CMD;
        end else begin
          trk_crc = 8'h00;
          trk_phase = cfd_pkg::PH_HDR1;
        end
      end
      cfd_pkg::PH_CMD: begin
        trk_cmd = b;
        trk_crc = crc_next(trk_crc, b);
        trk_phase = cfd_pkg::PH_DATA;
      end
      cfd_pkg::PH_DATA: begin
        trk_data = b;
        trk_crc = crc_next(trk_crc, b);
        trk_phase = cfd_pkg::PH_CRC;
      end
      cfd_pkg::PH_CRC: begin
        if (b == trk_crc && trk_data == cfd_pkg::DATA_ZERO) begin
          if (trk_cmd == cfd_pkg::CMD_ID) begin
            hit = 1'b1;
            kind = cfd_pkg::KIND_ID;
          end else if (trk_cmd == cfd_pkg::CMD_SELF) begin
            hit = 1'b1;
            kind = cfd_pkg::KIND_SELF;
          end
        end
        trk_crc = 8'h00;
        trk_phase = cfd_pkg::PH_HDR1;
      end
      default: begin
        if (b == cfd_pkg::HDR_BYTE) begin
          trk_crc = crc_next(8'h00, b);
          trk_phase = cfd_pkg::PH_HDR2;
        end else begin
          trk_crc = 8'h00;
          trk_phase = cfd_pkg::PH_HDR1;
        end
      end
    endcase
  endfunction

  // driver: new word only once the previous one has gone
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= 8'h00;
    end else if (!in_valid || in_fire) begin
      if (rx_queue.size() != 0 && !tx_pause && $urandom_range(0, 99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_rx_byte <= 8'($urandom);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_go) begin
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_cnt != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: predict on accepted input, check accepted output
  always @(posedge clk) begin
    logic hit;
    logic kind;
    logic want;
    if (!rst_n) begin
      in_fire <= 1'b0;
      trk_phase = cfd_pkg::PH_HDR1;
      trk_crc = 8'h00;
      trk_cmd = 8'h00;
      trk_data = 8'h00;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        words_in <= words_in + 1;
        track_byte(in_rx_byte, hit, kind);
        if (hit) begin
          kind_expect.push_back(kind);
        end
      end
      if (out_valid && !out_stall) begin
        if (kind_expect.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual command_kind=%0b",
                   $time, out_command_kind);
          errors++;
        end else begin
          want = kind_expect.pop_front();
          if (out_command_kind !== want) begin
            $display("%0t: command_kind mismatch, expected %0b, actual %0b",
                     $time, want, out_command_kind);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send(input logic [7:0] b);
    rx_queue.push_back(b);
    words_queued++;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] data,
                            input logic [7:0] crc_flip);
    logic [7:0] crc;
    crc = crc_next(8'h00, cfd_pkg::HDR_BYTE);
    crc = crc_next(crc, cfd_pkg::HDR_BYTE);
    crc = crc_next(crc_next(crc, cmd), data);
    send(cfd_pkg::HDR_BYTE);
    send(cfd_pkg::HDR_BYTE);
    send(cmd);
    send(data);
    send(crc ^ crc_flip);
  endtask

  // mostly well-formed frames; rest is broken headers, lone headers and noise
  task automatic random_traffic(input int n);
    int         cnt;
    int         r;
    int         pick;
    logic [7:0] cmd;
    logic [7:0] data;
    logic [7:0] flip;
    logic [7:0] b;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        pick = $urandom_range(0, 99);
        cmd = (pick < 40) ? cfd_pkg::CMD_ID : (pick < 80) ? cfd_pkg::CMD_SELF : 8'($urandom);
        data = ($urandom_range(0, 3) != 0) ? cfd_pkg::DATA_ZERO : 8'($urandom);
        flip = ($urandom_range(0, 9) != 0) ? 8'h00 : 8'($urandom_range(1, 255));
        send_frame(cmd, data, flip);
        cnt += 5;
      end else if (r < 80) begin
        b = 8'($urandom);
        if (b == cfd_pkg::HDR_BYTE) begin
          b = ~b;
        end
        send(cfd_pkg::HDR_BYTE);
        send(b);
        cnt += 2;
      end else if (r < 90) begin
        send(cfd_pkg::HDR_BYTE);
        cnt += 1;
      end else begin
        send(8'($urandom));
        cnt += 1;
      end
    end
  endtask

  task automatic start_phase(input int idle, input int stall, input int n);
    @(posedge clk);
    idle_pct = idle;
    stall_pct = stall;
    random_traffic(n);
  endtask

  task automatic drain();
    while (words_in != words_queued) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bad first headers, both commands, bad second header,
    // bad CRC, unknown command with header-valued data, non-zero data
    send(8'h00);
    send(8'hFF);
    send_frame(cfd_pkg::CMD_ID, cfd_pkg::DATA_ZERO, 8'h00);
    send(cfd_pkg::HDR_BYTE);
    send(8'hAA);
    send_frame(cfd_pkg::CMD_SELF, cfd_pkg::DATA_ZERO, 8'h00);
    send_frame(cfd_pkg::CMD_SELF, cfd_pkg::DATA_ZERO, 8'h01);
    send_frame(8'hFF, cfd_pkg::HDR_BYTE, 8'h00);
    send_frame(cfd_pkg::CMD_ID, 8'h01, 8'h00);
    drain();

    // long receiver hold-off while the sender keeps going
    start_phase(0, 0, 250);
    @(posedge clk);
    hold_go = 1'b1;
    @(posedge clk);
    hold_go = 1'b0;
    drain();

    start_phase(78, 0, 200);
    drain();
    start_phase(0, 78, 200);
    drain();

    // sender stops until every result is out
    start_phase(15, 15, 250);
    while (words_in + 100 < words_queued) begin
      @(posedge clk);
    end
    tx_pause = 1'b1;
    while (in_valid || kind_expect.size() != 0) begin
      @(posedge clk);
    end
    tx_pause = 1'b0;
    drain();

    start_phase(0, 0, 200);
    drain();

    while (kind_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
sv/cfd_pkg.sv
sv/cfd_frame_tracker.sv
sv/crc8_command_frame_detector_core.sv
verif/tb_top.sv
